>>> rtl/lpmd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
// No dependencies; imported by lpmd_core, lpmd_fifo and the top level.
package lpmd_pkg;

    localparam int unsigned LPMD_LIMIT_W       = 25;
    localparam int unsigned LPMD_OUT_DEPTH     = 4;
    localparam logic [2:0]  LPMD_LAST_LEN_BYTE = 3'd4;
    localparam logic [32:0] LPMD_HEADER_BYTES  = 33'd5;
    localparam logic [LPMD_LIMIT_W-1:0] LPMD_LIMIT_RESET = 25'd16777216;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_DATA_LOSS    = 2'd0;
    localparam logic [1:0] ERR_PRECONDITION = 2'd1;
    localparam logic [1:0] ERR_EXHAUSTED    = 2'd2;

    // configuration register indexes
    localparam logic CFG_GZIP_INPUT_ENABLED = 1'b0;
    localparam logic CFG_FRAME_SIZE_LIMIT   = 1'b1;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic       message_first;
        logic       message_last;
        logic       message_compressed;
        logic [1:0] error_code;
        logic       result_final;
    } lpmd_result_t;

    // what the deframer hands to the result queue in one cycle
    typedef struct packed {
        logic         valid0;
        logic         valid1;
        lpmd_result_t res0;
        lpmd_result_t res1;
    } lpmd_push_t;

endpackage

>>> rtl/lpmd_core.sv
// Framing state and per-request decode for the message deframer.
// Depends on lpmd_pkg; produces up to two results per accepted request.
module lpmd_core import lpmd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [7:0]              body_byte,
    input  logic                    byte_present,
    input  logic                    body_end,
    input  logic                    gzip_input_enabled,
    input  logic [LPMD_LIMIT_W-1:0] frame_size_limit,
    output lpmd_push_t              push
);

    logic [2:0]              header_count_reg, header_count_next;
    logic [31:0]             length_acc_reg, length_acc_next;
    logic [LPMD_LIMIT_W-1:0] remaining_reg, remaining_next;
    logic                    compressed_reg, compressed_next;
    logic                    in_payload_reg, in_payload_next;
    logic                    first_pending_reg, first_pending_next;
    logic                    ignoring_reg, ignoring_next;

    logic [31:0]  acc_new;
    logic [32:0]  total;
    logic         byte_valid, end_valid;
    lpmd_result_t byte_res, end_res;

    assign acc_new = {length_acc_reg[23:0], body_byte};
    assign total   = {1'b0, acc_new} + LPMD_HEADER_BYTES;

    always_comb begin
        header_count_next  = header_count_reg;
        length_acc_next    = length_acc_reg;
        remaining_next     = remaining_reg;
        compressed_next    = compressed_reg;
        in_payload_next    = in_payload_reg;
        first_pending_next = first_pending_reg;
        ignoring_next      = ignoring_reg;
        byte_valid         = 1'b0;
        end_valid          = 1'b0;
        byte_res           = '0;
        end_res            = '0;

        if (!ignoring_reg && byte_present) begin
            if (in_payload_reg) begin
                byte_valid                  = 1'b1;
                byte_res.result_kind        = KIND_PAYLOAD;
                byte_res.payload_byte       = body_byte;
                byte_res.message_first      = first_pending_reg;
                byte_res.message_last       = (remaining_reg == LPMD_LIMIT_W'(1));
                byte_res.message_compressed = compressed_reg;
                first_pending_next          = 1'b0;
                remaining_next              = remaining_reg - LPMD_LIMIT_W'(1);
                if (remaining_reg == LPMD_LIMIT_W'(1)) begin
                    in_payload_next   = 1'b0;
                    header_count_next = '0;
                end
            end else if (header_count_reg == 3'd0) begin
                compressed_next   = body_byte[0];
                length_acc_next   = '0;
                header_count_next = 3'd1;
            end else begin
                length_acc_next   = acc_new;
                header_count_next = header_count_reg + 3'd1;
                if (header_count_reg == LPMD_LAST_LEN_BYTE) begin
                    header_count_next = '0;
                    if (total > {8'd0, frame_size_limit}) begin
                        byte_valid           = 1'b1;
                        byte_res.result_kind = KIND_ERROR;
                        byte_res.error_code  = ERR_EXHAUSTED;
                        ignoring_next        = 1'b1;
                    end else if (compressed_reg && !gzip_input_enabled) begin
                        byte_valid           = 1'b1;
                        byte_res.result_kind = KIND_ERROR;
                        byte_res.error_code  = ERR_PRECONDITION;
                        ignoring_next        = 1'b1;
                    end else if (acc_new == 32'd0) begin
                        byte_valid                  = 1'b1;
                        byte_res.result_kind        = KIND_EMPTY;
                        byte_res.message_compressed = compressed_reg;
                    end else begin
                        // size check bounds the length below 2^25
                        remaining_next     = acc_new[LPMD_LIMIT_W-1:0];
                        in_payload_next    = 1'b1;
                        first_pending_next = 1'b1;
                    end
                end
            end
        end

        // end of body is judged on the state after the byte
        if (body_end && !ignoring_next) begin
            end_valid            = 1'b1;
            end_res.result_final = 1'b1;
            if (in_payload_next || header_count_next != 3'd0) begin
                end_res.result_kind = KIND_ERROR;
                end_res.error_code  = ERR_DATA_LOSS;
            end else begin
                end_res.result_kind = KIND_FINISHED;
            end
            ignoring_next = 1'b1;
        end
        byte_res.result_final = !end_valid;

        push.valid0 = accept && (byte_valid || end_valid);
        push.valid1 = accept && byte_valid && end_valid;
        push.res0   = byte_valid ? byte_res : end_res;
        push.res1   = end_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg  <= '0;
            length_acc_reg    <= '0;
            remaining_reg     <= '0;
            compressed_reg    <= 1'b0;
            in_payload_reg    <= 1'b0;
            first_pending_reg <= 1'b0;
            ignoring_reg      <= 1'b0;
        end else if (accept) begin
            header_count_reg  <= header_count_next;
            length_acc_reg    <= length_acc_next;
            remaining_reg     <= remaining_next;
            compressed_reg    <= compressed_next;
            in_payload_reg    <= in_payload_next;
            first_pending_reg <= first_pending_next;
            ignoring_reg      <= ignoring_next;
        end
    end

endmodule

>>> rtl/lpmd_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on lpmd_pkg; DEPTH must be a power of two, at least 2.
module lpmd_fifo import lpmd_pkg::*; #(
    parameter int unsigned DEPTH = LPMD_OUT_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  lpmd_push_t   push,
    output logic         room_for_two,
    output logic         out_valid,
    input  logic         out_ready,
    output lpmd_result_t out_data
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lpmd_result_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    wr_n;
    logic          rd;

    assign wr_n         = {1'b0, push.valid0} + {1'b0, push.valid1};
    assign rd           = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= CW'(DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(wr_n);
        rd_ptr_next = rd_ptr_reg + PW'(rd);
        count_next  = count_reg + CW'(wr_n) - CW'(rd);
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1) begin
            mem[wr_ptr_reg + PW'(1)] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/length_prefixed_message_deframer.sv
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg, lpmd_core and lpmd_fifo.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    body_byte, byte_present, body_end
//  m_        out        m_valid / m_ready    one result per transfer
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wr_data
//
// One request is taken per cycle while s_ready is high; its results land in the
// result queue at the same edge and leave on m_ in order, one per cycle while
// m_ready is high. A request yielding two results (a byte plus body end) needs
// an extra output transfer; the queue read port sets the sustained output rate.
// s_ready is high while the queue can hold two more results.
// Reset (aresetn low at a clock edge) clears framing state and empties the queue.
module length_prefixed_message_deframer import lpmd_pkg::*; #(
    parameter int unsigned OUT_DEPTH = LPMD_OUT_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration writes
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [LPMD_LIMIT_W-1:0] cfg_wr_data,

    // request body input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_body_byte,
    input  logic                    s_byte_present,
    input  logic                    s_body_end,

    // result output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_result_kind,
    output logic [7:0]              m_payload_byte,
    output logic                    m_message_first,
    output logic                    m_message_last,
    output logic                    m_message_compressed,
    output logic [1:0]              m_error_code,
    output logic                    m_result_final
);

    logic                    gzip_en_reg;
    logic [LPMD_LIMIT_W-1:0] limit_reg;
    logic                    s_accept;
    logic                    room_for_two;
    lpmd_push_t              push;
    lpmd_result_t            out_data;

    // configuration registers: user to write only while block idle; not enforced
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gzip_en_reg <= 1'b0;
            limit_reg   <= LPMD_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GZIP_INPUT_ENABLED: gzip_en_reg <= cfg_wr_data[0];
                CFG_FRAME_SIZE_LIMIT:   limit_reg   <= cfg_wr_data;
                default:                gzip_en_reg <= gzip_en_reg;
            endcase
        end
    end

    // accept a request whenever the queue can absorb its worst case
    assign s_ready  = room_for_two;
    assign s_accept = s_valid && s_ready;

    // decode header / payload bytes and body end
    lpmd_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .accept             (s_accept),
        .body_byte          (s_body_byte),
        .byte_present       (s_byte_present),
        .body_end           (s_body_end),
        .gzip_input_enabled (gzip_en_reg),
        .frame_size_limit   (limit_reg),
        .push               (push)
    );

    // hold results until the consumer takes them
    lpmd_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_data     (out_data)
    );

    assign m_result_kind        = out_data.result_kind;
    assign m_payload_byte       = out_data.payload_byte;
    assign m_message_first      = out_data.message_first;
    assign m_message_last       = out_data.message_last;
    assign m_message_compressed = out_data.message_compressed;
    assign m_error_code         = out_data.error_code;
    assign m_result_final       = out_data.result_final;

endmodule

>>> sim/length_prefixed_message_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for length_prefixed_message_deframer: streams framed request
// bodies, predicts each result as requests are accepted and checks the result channel.
// Depends on lpmd_pkg and the deframer RTL only.
module length_prefixed_message_deframer_tb;
    import lpmd_pkg::*;

    // One request on the body channel, as queued for the driver.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       byte_present;
        logic       body_end;
    } body_req_t;

    // Ways to close the body; only one can happen per run, since the block
    // goes deaf after finishing or failing and reset is applied once.
    typedef enum int {
        CLOSE_CLEAN,
        CLOSE_WITH_BYTE,
        CLOSE_TRUNCATED,
        CLOSE_OVERSIZE,
        CLOSE_NO_GZIP,
        CLOSE_TINY_LIMIT
    } body_close_e;

    localparam int unsigned HEADER_LEN      = 5;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned TARGET_REQS     = 1200;
    localparam int unsigned MAX_SHOWN       = 10;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_wr_en      = 1'b0;
    logic                    cfg_index      = CFG_GZIP_INPUT_ENABLED;
    logic [LPMD_LIMIT_W-1:0] cfg_wr_data    = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_body_byte    = '0;
    logic                    s_byte_present = 1'b0;
    logic                    s_body_end     = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [1:0]              m_result_kind;
    logic [7:0]              m_payload_byte;
    logic                    m_message_first;
    logic                    m_message_last;
    logic                    m_message_compressed;
    logic [1:0]              m_error_code;
    logic                    m_result_final;

    length_prefixed_message_deframer DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_body_byte          (s_body_byte),
        .s_byte_present       (s_byte_present),
        .s_body_end           (s_body_end),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_kind        (m_result_kind),
        .m_payload_byte       (m_payload_byte),
        .m_message_first      (m_message_first),
        .m_message_last       (m_message_last),
        .m_message_compressed (m_message_compressed),
        .m_error_code         (m_error_code),
        .m_result_final       (m_result_final)
    );

    // Framing state of the predictor, mirroring what the block keeps.
    logic [2:0]              hdr_seen       = '0;
    logic [31:0]             len_acc        = '0;
    logic [LPMD_LIMIT_W-1:0] bytes_left     = '0;
    logic                    msg_compressed = 1'b0;
    logic                    in_payload     = 1'b0;
    logic                    first_due      = 1'b0;
    logic                    body_closed    = 1'b0;

    // Predictor copy of the configuration registers.
    logic                    gzip_on    = 1'b0;
    logic [LPMD_LIMIT_W-1:0] size_limit = LPMD_LIMIT_RESET;

    lpmd_result_t expected_results [$];
    body_req_t    pending_reqs [$];

    int unsigned req_count  = 0;
    int unsigned fail_count = 0;
    int unsigned send_gap   = 0;
    int unsigned recv_gap   = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_asks  = 0;
    int unsigned holds_done = 0;
    bit          quiet      = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: advance the framing state by one accepted request and
    // queue the results it must cause, final flag on the last of them.
    // ------------------------------------------------------------------
    task automatic deframe_request(input logic [7:0] b, input logic present,
                                   input logic ends);
        lpmd_result_t produced [2];
        int           n;
        logic [32:0]  frame_total;
        n = 0;
        produced[0] = '0;
        produced[1] = '0;
        // once finished or failed, drop everything until reset
        if (body_closed)
            return;
        if (present) begin
            if (in_payload) begin
                produced[n].result_kind        = KIND_PAYLOAD;
                produced[n].payload_byte       = b;
                produced[n].message_first      = first_due;
                produced[n].message_last       = (bytes_left == 1);
                produced[n].message_compressed = msg_compressed;
                n++;
                first_due  = 1'b0;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    in_payload = 1'b0;
                    hdr_seen   = '0;
                end
            end else if (hdr_seen == 0) begin
                // flags byte: only bit 0 matters
                msg_compressed = b[0];
                len_acc        = '0;
                hdr_seen       = 3'd1;
            end else begin
                len_acc  = {len_acc[23:0], b};
                hdr_seen = hdr_seen + 1'b1;
                if (hdr_seen == HEADER_LEN) begin
                    hdr_seen    = '0;
                    frame_total = {1'b0, len_acc} + LPMD_HEADER_BYTES;
                    // size check comes before the compression check
                    if (frame_total > {8'd0, size_limit}) begin
                        produced[n].result_kind = KIND_ERROR;
                        produced[n].error_code  = ERR_EXHAUSTED;
                        n++;
                        body_closed = 1'b1;
                    end else if (msg_compressed && !gzip_on) begin
                        produced[n].result_kind = KIND_ERROR;
                        produced[n].error_code  = ERR_PRECONDITION;
                        n++;
                        body_closed = 1'b1;
                    end else if (len_acc == 0) begin
                        produced[n].result_kind        = KIND_EMPTY;
                        produced[n].message_compressed = msg_compressed;
                        n++;
                    end else begin
                        bytes_left = len_acc[LPMD_LIMIT_W-1:0];
                        in_payload = 1'b1;
                        first_due  = 1'b1;
                    end
                end
            end
        end
        // the byte goes first, then the end of body
        if (ends && !body_closed) begin
            if (in_payload || hdr_seen != 0) begin
                produced[n].result_kind = KIND_ERROR;
                produced[n].error_code  = ERR_DATA_LOSS;
            end else begin
                produced[n].result_kind = KIND_FINISHED;
            end
            n++;
            body_closed = 1'b1;
        end
        if (n > 0)
            produced[n-1].result_final = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(produced[i]);
    endtask

    function automatic string show_result(input lpmd_result_t r);
        return $sformatf("kind %0d byte %02h first %0b last %0b comp %0b err %0d final %0b",
                         r.result_kind, r.payload_byte, r.message_first, r.message_last,
                         r.message_compressed, r.error_code, r.result_final);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building blocks.
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [7:0] b, input logic present, input logic ends);
        body_req_t r;
        r.body_byte    = b;
        r.byte_present = present;
        r.body_end     = ends;
        pending_reqs.push_back(r);
        // bare markers with no end are ignored by the block; leave them uncounted
        if (present || ends)
            req_count++;
    endtask

    // Sprinkle an occasional bare marker that the block must skip.
    task automatic queue_noise();
        if ($urandom_range(0, 19) == 0)
            queue_req(8'($urandom), 1'b0, 1'b0);
    endtask

    // Flags byte, then the length big-endian; optionally end the body on the
    // last length byte.
    task automatic queue_header(input logic [7:0] flags, input logic [31:0] len,
                                input logic ends_on_last);
        queue_req(flags, 1'b1, 1'b0);
        for (int i = 3; i >= 0; i--) begin
            queue_noise();
            queue_req(len[8*i +: 8], 1'b1, (i == 0) && ends_on_last);
        end
    endtask

    task automatic queue_payload(input int unsigned count, input logic ends_on_last);
        for (int unsigned i = 0; i < count; i++) begin
            queue_noise();
            queue_req(8'($urandom), 1'b1, (i == count - 1) && ends_on_last);
        end
    endtask

    // Mostly short messages, some empty, a few long ones; always within the limit.
    function automatic int unsigned pick_len();
        int unsigned room;
        int unsigned len;
        int unsigned roll;
        room = (size_limit > HEADER_LEN) ? size_limit - HEADER_LEN : 0;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            len = 0;
        else if (roll < 80)
            len = $urandom_range(1, 8);
        else if (roll < 97)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 600);
        return (len > room) ? room : len;
    endfunction

    // A well-formed message under the current settings, random content.
    task automatic queue_message();
        logic [7:0]  flags;
        int unsigned len;
        flags    = 8'($urandom);
        flags[0] = flags[0] & gzip_on;
        len      = pick_len();
        queue_header(flags, len, 1'b0);
        queue_payload(len, 1'b0);
    endtask

    // Write one register; update the predictor copy when the write is driven.
    task automatic cfg_write(input logic idx, input logic [LPMD_LIMIT_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        if (idx == CFG_GZIP_INPUT_ENABLED)
            gzip_on = data[0];
        else
            size_limit = data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Gzip write with junk in the unused upper bits.
    task automatic cfg_write_gzip(input logic gz);
        logic [LPMD_LIMIT_W-1:0] data;
        data    = LPMD_LIMIT_W'($urandom);
        data[0] = gz;
        cfg_write(CFG_GZIP_INPUT_ENABLED, data);
    endtask

    // Hold until every queued request went in and every result came out,
    // then let the pipeline drain a little more.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One random phase: new settings, then a run of well-formed messages.
    task automatic run_phase(input int unsigned reqs, input bit with_hold);
        logic [LPMD_LIMIT_W-1:0] lim;
        int unsigned             stop_at;
        int unsigned             which;
        case ($urandom_range(0, 4))
            0:       lim = LPMD_LIMIT_W'(HEADER_LEN);
            1:       lim = LPMD_LIMIT_W'($urandom_range(6, 40));
            2:       lim = LPMD_LIMIT_W'($urandom_range(41, 4096));
            3:       lim = LPMD_LIMIT_W'($urandom_range(4097, LPMD_LIMIT_RESET - 1));
            default: lim = LPMD_LIMIT_RESET;
        endcase
        which = $urandom_range(0, 2);
        if (which != 1)
            cfg_write_gzip(1'($urandom_range(0, 1)));
        if (which != 0)
            cfg_write(CFG_FRAME_SIZE_LIMIT, lim);
        // ask the receiver for a long hold-off while the sender keeps pushing
        if (with_hold)
            hold_asks++;
        stop_at = req_count + reqs;
        while (req_count < stop_at) begin
            queue_message();
            queue_noise();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued requests, with random idle bursts between them.
    // Valid stays up with the payload held until the request is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_driver
        body_req_t next_req;
        bit        busy;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                deframe_request(s_body_byte, s_byte_present, s_body_end);
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 10);
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req       = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_body_byte    <= next_req.body_byte;
                    s_byte_present <= next_req.byte_present;
                    s_body_end     <= next_req.body_end;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken result against the oldest expectation,
    // and drive ready with random stalls and the requested long hold-off.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        lpmd_result_t got;
        lpmd_result_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_result_kind, m_payload_byte, m_message_first, m_message_last,
                       m_message_compressed, m_error_code, m_result_final};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("%0t: result with nothing expected: %s",
                                 $realtime, show_result(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected %s", show_result(want));
                            $display("    actual   %s", show_result(got));
                        end
                    end
                end
            end
            if (hold_left == 0 && holds_done != hold_asks) begin
                holds_done++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                if (recv_gap == 0 && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 10);
                if (recv_gap != 0) begin
                    recv_gap--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin : test_sequence
        body_close_e close_kind;
        logic [7:0]  flags;
        logic [31:0] len;
        int unsigned keep;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset settings, high flag bits with compressed clear,
        // extreme payload values, an empty message and a bare marker.
        queue_header(8'hFE, 32'd1, 1'b0);
        queue_req(8'hFF, 1'b1, 1'b0);
        queue_header(8'h00, 32'd0, 1'b0);
        queue_req(8'h5A, 1'b0, 1'b0);
        queue_header(8'h00, 32'd2, 1'b0);
        queue_req(8'h00, 1'b1, 1'b0);
        queue_req(8'h80, 1'b1, 1'b0);
        wait_idle();

        // Smallest limit still admits an empty frame; gzip on admits compression.
        cfg_write_gzip(1'b1);
        cfg_write(CFG_FRAME_SIZE_LIMIT, LPMD_LIMIT_W'(HEADER_LEN));
        queue_header(8'h01, 32'd0, 1'b0);
        wait_idle();
        cfg_write(CFG_FRAME_SIZE_LIMIT, LPMD_LIMIT_W'(HEADER_LEN + 1));
        queue_header(8'hFF, 32'd1, 1'b0);
        queue_req(8'h7F, 1'b1, 1'b0);
        wait_idle();

        // Random phases; the second one stalls the result side for a long stretch.
        run_phase(150, 1'b0);
        run_phase(150, 1'b1);
        while (req_count < TARGET_REQS - 150)
            run_phase($urandom_range(60, 200), 1'b0);
        // no idling on either side from here on
        quiet = 1'b1;
        run_phase(150, 1'b0);

        // Close the body in one of the ways it can end.
        close_kind = body_close_e'($urandom_range(0, 5));
        case (close_kind)
            CLOSE_CLEAN: begin
                cfg_write_gzip(1'($urandom_range(0, 1)));
                queue_message();
                queue_req(8'($urandom), 1'b0, 1'b1);
            end
            CLOSE_WITH_BYTE: begin
                // last payload byte and body end in the same request
                cfg_write(CFG_FRAME_SIZE_LIMIT, LPMD_LIMIT_RESET);
                flags    = 8'($urandom);
                flags[0] = flags[0] & gzip_on;
                len      = $urandom_range(1, 20);
                queue_header(flags, len, 1'b0);
                queue_payload(len, 1'b1);
            end
            CLOSE_TRUNCATED: begin
                cfg_write(CFG_FRAME_SIZE_LIMIT, LPMD_LIMIT_RESET);
                flags    = 8'($urandom);
                flags[0] = flags[0] & gzip_on;
                if ($urandom_range(0, 1) == 0) begin
                    // stop inside the header, or just as its last byte arrives
                    keep = $urandom_range(1, 4);
                    queue_req(flags, 1'b1, 1'b0);
                    for (int unsigned i = 1; i < keep; i++)
                        queue_req(8'($urandom), 1'b1, 1'b0);
                    queue_req(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
                end else begin
                    // stop inside the payload, short of its last byte
                    len  = $urandom_range(2, 30);
                    keep = $urandom_range(0, len - 2);
                    queue_header(flags, len, 1'b0);
                    queue_payload(keep, 1'b0);
                    queue_req(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
                end
            end
            CLOSE_OVERSIZE: begin
                cfg_write(CFG_FRAME_SIZE_LIMIT,
                          LPMD_LIMIT_W'($urandom_range(HEADER_LEN, LPMD_LIMIT_RESET)));
                case ($urandom_range(0, 2))
                    0:       len = size_limit - HEADER_LEN + 1;
                    1:       len = 32'hFFFF_FFFF;
                    default: len = $urandom | 32'h8000_0000;
                endcase
                queue_header(8'($urandom), len, 1'($urandom_range(0, 1)));
            end
            CLOSE_NO_GZIP: begin
                cfg_write_gzip(1'b0);
                cfg_write(CFG_FRAME_SIZE_LIMIT, LPMD_LIMIT_RESET);
                flags    = 8'($urandom);
                flags[0] = 1'b1;
                queue_header(flags, $urandom_range(0, 10), 1'($urandom_range(0, 1)));
            end
            default: begin
                // a limit under the header size rejects every frame
                cfg_write(CFG_FRAME_SIZE_LIMIT,
                          LPMD_LIMIT_W'($urandom_range(0, HEADER_LEN - 1)));
                queue_header(8'($urandom), 32'd0, 1'($urandom_range(0, 1)));
            end
        endcase
        wait_idle();

        // Anything after the close must be dropped.
        queue_message();
        queue_req(8'($urandom), 1'b1, 1'b1);
        queue_req(8'($urandom), 1'b0, 1'b1);
        wait_idle();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("length_prefixed_message_deframer_tb: done, clean");
        else
            $display("length_prefixed_message_deframer_tb: done, errors");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("length_prefixed_message_deframer_tb: done, errors");
        $finish;
    end

endmodule
